### hw/rtl/ucl_pkg.sv
// Shared types, codes and keyword tables of the command line recognizer.
package ucl_pkg;

   localparam int LINE_BYTES = 32;
   localparam int LEN_W      = $clog2(LINE_BYTES);
   localparam int KW_COUNT   = 9;
   localparam int KW_MAX     = 13;
   localparam int KW_IDX_W   = $clog2(KW_MAX);

   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_TILDE = 8'd126;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef enum logic [1:0] {
      ECHO_NONE    = 2'd0,
      ECHO_BYTE    = 2'd1,
      ECHO_ERASE   = 2'd2,
      ECHO_NEWLINE = 2'd3
   } echo_kind_type;

   typedef enum logic [2:0] {
      LS_NONE    = 3'd0,
      LS_EMPTY   = 3'd1,
      LS_TOOLONG = 3'd2,
      LS_UNKNOWN = 3'd3,
      LS_RECOG   = 3'd4
   } line_status_type;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_HOME   = 3'd1,
      CMD_START  = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_ESTOP  = 3'd4,
      CMD_RESET  = 3'd5,
      CMD_STATUS = 3'd6
   } command_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK
   } state_type;

   typedef logic [7:0] kw_row_type [0:KW_MAX-1];

   localparam kw_row_type KW_TEXT [0:KW_COUNT-1] = '{
      '{"h","o","m","e",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"s","t","a","r","t",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"s","t","o","p",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"e","s","t","o","p",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"e","-","s","t","o","p",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"e","m","e","r","g","e","n","c","y",8'h0,8'h0,8'h0,8'h0},
      '{"e","m","e","r","g","e","n","c","y","s","t","o","p"},
      '{"r","e","s","e","t",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0},
      '{"s","t","a","t","u","s",8'h0,8'h0,8'h0,8'h0,8'h0,8'h0,8'h0}
   };

   localparam logic [KW_IDX_W:0] KW_LEN [0:KW_COUNT-1] = '{
      5'd4, 5'd5, 5'd4, 5'd5, 5'd6, 5'd9, 5'd13, 5'd5, 5'd6
   };

   localparam command_code_type KW_CODE [0:KW_COUNT-1] = '{
      CMD_HOME, CMD_START, CMD_STOP, CMD_ESTOP, CMD_ESTOP, CMD_ESTOP, CMD_ESTOP,
      CMD_RESET, CMD_STATUS
   };

endpackage

### hw/rtl/ucl_if.sv
// Request and response channel interfaces of the command line recognizer.
interface ucl_req_if
   import ucl_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucl_rsp_if
   import ucl_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] echo_kind;
   logic [7:0] echo_byte;
   logic [2:0] line_status;
   logic [2:0] command_code;

   modport source (output valid, output echo_kind, output echo_byte,
                   output line_status, output command_code, input ready);
   modport sink   (input valid, input echo_kind, input echo_byte,
                   input line_status, input command_code, output ready);
endinterface

### hw/rtl/uart_command_line_recognizer_top.sv
// Top level of the serial console command line recognizer.
//
// Takes one received byte per request and answers each with exactly one
// response. Printable bytes (32..126), at most 31 per line, are stored and are
// echoed; on a full line they are dropped and the line is marked too long.
// Backspace/DEL erases the last byte. CR or LF ends the line: the response
// carries a newline echo, the line status and, if the first word of the
// line names a command (case-insensitive, leading spaces skipped), its code.
// Every byte but a line end that starts a scan is answered in the cycle after
// it is taken; a new request can be taken while the response register is
// empty or drains. A line end on a non-empty, non-overflowed line scans the
// line store through its single read port, a read and a check state per byte,
// stopping at the end of the first word. No requests are taken during the
// scan. The line store needs no clearing pass after reset.
module uart_command_line_recognizer_top
   import ucl_pkg::*;
   (
      input  logic       clock,
      input  logic       reset,
      ucl_req_if.sink    req_ch,
      ucl_rsp_if.source  rsp_ch
   );

   // line store: one write port (edit), one registered read port (scan)
   logic [7:0]       line_store [0:LINE_BYTES-1];
   logic [7:0]       rd_data_ff;
   logic             mem_we;

   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;

   // scan state
   logic [LEN_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    widx_ff, widx_in;
   logic                in_word_ff, in_word_in;
   logic [KW_COUNT-1:0] alive_ff, alive_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   echo_kind_type    rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   line_status_type  rsp_status_ff, rsp_status_in;
   command_code_type rsp_code_ff, rsp_code_in;

   logic             req_fire;
   logic             out_free;

   // response register empties or drains this cycle
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.echo_kind    = rsp_kind_ff;
   assign rsp_ch.echo_byte    = rsp_byte_ff;
   assign rsp_ch.line_status  = rsp_status_ff;
   assign rsp_ch.command_code = rsp_code_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store[len_ff] <= req_ch.rx_byte;
      end
      rd_data_ff <= line_store[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      widx_ff       <= widx_in;
      in_word_ff    <= in_word_in;
      alive_ff      <= alive_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_status_ff <= rsp_status_in;
      rsp_code_ff   <= rsp_code_in;
   end

   always_comb begin
      logic [7:0]          b;
      logic [7:0]          lc;
      logic                last;
      logic                finish;
      logic [LEN_W-1:0]    widx_nx;
      logic [KW_COUNT-1:0] alive_nx;
      command_code_type    code;

      state_in      = state_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      pos_in        = pos_ff;
      widx_in       = widx_ff;
      in_word_in    = in_word_ff;
      alive_in      = alive_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_status_in = rsp_status_ff;
      rsp_code_in   = rsp_code_ff;
      mem_we        = 1'b0;

      b        = rd_data_ff;
      lc       = ((b >= CH_UA) && (b <= CH_UZ)) ? (b | CASE_BIT) : b;
      last     = (pos_ff == len_ff - LEN_W'(1));
      finish   = 1'b0;
      widx_nx  = widx_ff;
      alive_nx = alive_ff;
      code     = CMD_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // default answer: ignored byte, all fields zero
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ECHO_NONE;
               rsp_byte_in   = 8'h00;
               rsp_status_in = LS_NONE;
               rsp_code_in   = CMD_NONE;
               priority if (req_ch.rx_byte == CH_CR || req_ch.rx_byte == CH_LF) begin
                  rsp_kind_in = ECHO_NEWLINE;
                  priority if (ovf_ff) begin
                     rsp_status_in = LS_TOOLONG;
                     len_in        = '0;
                     ovf_in        = 1'b0;
                  end else if (len_ff == '0) begin
                     rsp_status_in = LS_EMPTY;
                  end else begin
                     // response is built at the end of the scan
                     rsp_valid_in = 1'b0;
                     state_in     = ST_SCAN_RD;
                     pos_in       = '0;
                     widx_in      = '0;
                     in_word_in   = 1'b0;
                     alive_in     = '1;
                  end
               end else if (req_ch.rx_byte == CH_BS || req_ch.rx_byte == CH_DEL) begin
                  if (len_ff != '0) begin
                     len_in      = len_ff - LEN_W'(1);
                     rsp_kind_in = ECHO_ERASE;
                  end
               end else if (req_ch.rx_byte >= CH_SPACE && req_ch.rx_byte <= CH_TILDE) begin
                  if (len_ff != LEN_W'(LINE_BYTES - 1)) begin
                     mem_we      = 1'b1;
                     len_in      = len_ff + LEN_W'(1);
                     rsp_kind_in = ECHO_BYTE;
                     rsp_byte_in = req_ch.rx_byte;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  // other control bytes and bytes above 126 are dropped
               end
            end
         end
         ST_SCAN_RD: begin
            // read of line_store[pos_ff] lands in rd_data_ff
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            priority if (!in_word_ff && b == CH_SPACE) begin
               finish = last;
            end else if (in_word_ff && b == CH_SPACE) begin
               finish = 1'b1;
            end else begin
               for (int k = 0; k < KW_COUNT; k++) begin
                  alive_nx[k] = alive_ff[k]
                     && (widx_ff < LEN_W'(KW_LEN[k]))
                     && (lc == KW_TEXT[k][widx_ff[KW_IDX_W-1:0]]);
               end
               // word index only matters while below KW_MAX; hold at top
               if (widx_ff != '1) begin
                  widx_nx = widx_ff + LEN_W'(1);
               end
               finish = last;
            end
            widx_in    = widx_nx;
            alive_in   = alive_nx;
            in_word_in = in_word_ff || (b != CH_SPACE);
            pos_in     = pos_ff + LEN_W'(1);
            if (finish) begin
               // first keyword in table order wins
               for (int k = KW_COUNT - 1; k >= 0; k--) begin
                  if (alive_nx[k] && widx_nx == LEN_W'(KW_LEN[k])) begin
                     code = KW_CODE[k];
                  end
               end
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ECHO_NEWLINE;
               rsp_byte_in   = 8'h00;
               rsp_status_in = (code != CMD_NONE) ? LS_RECOG : LS_UNKNOWN;
               rsp_code_in   = code;
               len_in        = '0;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // requests only enter while no scan is running
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (state_ff == ST_IDLE))
      else $error("request taken during a scan");

   // a command code only comes with a recognized line
   a_code_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_code_ff != CMD_NONE) |-> (rsp_status_ff == LS_RECOG))
      else $error("command code without recognized status");

   // stored length never reaches the store depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_BYTES - 1))
      else $error("line length out of range");

   // finishing a scan delivers a line end response and clears the line
   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_CHK && state_in == ST_IDLE) |=>
         (rsp_valid_ff && rsp_kind_ff == ECHO_NEWLINE && len_ff == '0 && !ovf_ff))
      else $error("scan end without line end response");

   // a scan only runs on a non-empty line without overflow
   a_ovf_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (!ovf_ff && len_ff != '0))
      else $error("scan started on empty or overflowed line");

endmodule
